@@ rtl/erm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_pkg
// Shared widths, codes and types of the echo ranging minimum tracker.
// ----------------------------------------------------------------------------
package erm_pkg;

  localparam int NUM_SENSORS = 4;    // 1 .. 4
  localparam int ECHO_W      = 4;
  localparam int BTN_W       = 4;
  localparam int IDX_W       = 2;
  localparam int PULSE_W     = 16;
  localparam int DIST_W      = 24;
  localparam int PROD_W      = 26;   // pulse count times scale
  localparam int TARGET_W    = 16;
  localparam int DEB_W       = 8;
  localparam int SCALE_W     = 10;
  localparam int WIN_W       = 10;
  localparam int CFG_W       = 10;
  localparam int CFG_ADDR_W  = 2;
  localparam int S_TDATA_W   = 16;
  localparam int M_TDATA_W   = 48;

  localparam logic [DEB_W-1:0]    THRESHOLD_RST = 8'd20;
  localparam logic [SCALE_W-1:0]  SCALE_RST     = 10'd165;
  localparam logic [WIN_W-1:0]    WINDOW_RST    = 10'd50;
  localparam logic [TARGET_W-1:0] TARGET_RST    = 16'd20;

  localparam logic [TARGET_W-1:0] TARGET_STEP_BIG   = 16'd200;
  localparam logic [TARGET_W-1:0] TARGET_STEP_SMALL = 16'd10;
  localparam logic [TARGET_W-1:0] TARGET_KNEE       = 16'd200;

  // button positions in buttons_pressed
  localparam int BTN_MODE = 0;
  localparam int BTN_UP   = 1;
  localparam int BTN_DOWN = 2;
  localparam int BTN_ZERO = 3;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_SCALE     = 2'd1,
    REG_WINDOW    = 2'd2
  } reg_e;

  // per-lane control for one item
  typedef struct packed {
    logic tick;
    logic echo;
    logic clear;
    logic arm;
  } lane_ctrl_t;

  // result item, packed so that the last field lands in the lowest bits
  typedef struct packed {
    logic [ECHO_W-1:0]   sensors_armed;
    logic                start_accepted;
    logic                near_flag;
    logic [DIST_W-1:0]   min_distance_tenths;
    logic                distance_valid;
    logic [TARGET_W-1:0] target_cm;
    logic                config_mode;
  } res_t;

endpackage

@@ rtl/echo_ranging_min_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_ranging_min_tracker
// Multi-sensor echo ranging with running minimum distance, debounced buttons
// and a near-window flag.
//
//   channel   dir  handshake              payload
//   s_axis    in   tvalid/tready          tuser: op; tdata: echo, buttons, index
//   m_axis    out  tvalid/tready          tdata: one result item
//   cfg       in   cfg_we_i (no stall)    cfg_addr_i, cfg_wdata_i
//
// One item per cycle while s_axis_tready is high. An accepted item updates lane,
// minimum and button state at its edge; once the output register is free, the
// near flag is computed from that state and loaded with the rest of the result.
// s_axis_tready drops only while a processed item waits for a full, stalled
// output register. Reset is asynchronous, active low, and resets all state but
// the output data register; config registers go to their default values.
// ----------------------------------------------------------------------------
module echo_ranging_min_tracker
  import erm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [3:0] echo_levels, [7:4] buttons_pressed, [9:8] sensor_index, rest zero
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  // [0] op
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] config_mode, [16:1] target_cm, [17] distance_valid,
  // [41:18] min_distance_tenths, [42] near_flag, [43] start_accepted,
  // [47:44] sensors_armed
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i
);

  // configuration registers
  logic [DEB_W-1:0]   thr_q;
  logic [SCALE_W-1:0] scale_q;
  logic [WIN_W-1:0]   win_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= THRESHOLD_RST;
      scale_q <= SCALE_RST;
      win_q   <= WINDOW_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_THRESHOLD: thr_q   <= cfg_wdata_i[DEB_W-1:0];
        REG_SCALE:     scale_q <= cfg_wdata_i[SCALE_W-1:0];
        REG_WINDOW:    win_q   <= cfg_wdata_i[WIN_W-1:0];
        default:       ;
      endcase
    end
  end

  // input decode
  logic              in_acc;
  op_e               op;
  logic [ECHO_W-1:0] echo;
  logic [BTN_W-1:0]  buttons;
  logic [IDX_W-1:0]  sensor_idx;
  logic              tick;
  logic              start_ok;

  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign op         = op_e'(s_axis_tuser);
  assign echo       = s_axis_tdata[ECHO_W-1:0];
  assign buttons    = s_axis_tdata[ECHO_W +: BTN_W];
  assign sensor_idx = s_axis_tdata[ECHO_W+BTN_W +: IDX_W];
  assign tick       = in_acc && (op == OP_TICK);

  // sensor lanes
  logic [NUM_SENSORS-1:0] sel;
  logic [NUM_SENSORS-1:0] armed_vec;
  logic [NUM_SENSORS-1:0] fin_vec;
  logic [DIST_W-1:0]      lane_dist [NUM_SENSORS];
  lane_ctrl_t             lane_ctrl [NUM_SENSORS];

  // an index beyond the sensors matches no lane and is ignored
  always_comb begin
    for (int i = 0; i < NUM_SENSORS; i++) begin
      sel[i] = (32'(sensor_idx) == i);
    end
  end

  assign start_ok = in_acc && (op == OP_START) && (sel != '0) && ((sel & armed_vec) == '0);

  for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_lane
    logic echo_bit;
    if (g < ECHO_W) begin : g_echo
      assign echo_bit = echo[g];
    end else begin : g_no_echo
      assign echo_bit = 1'b0;
    end

    assign lane_ctrl[g] = '{tick: tick, echo: echo_bit, clear: start_ok, arm: sel[g]};

    erm_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (lane_ctrl[g]),
      .scale_i  (scale_q),
      .armed_o  (armed_vec[g]),
      .finish_o (fin_vec[g]),
      .dist_o   (lane_dist[g])
    );
  end

  logic [DIST_W-1:0] min_dist;
  logic              have_dist;

  erm_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .finish_i (fin_vec),
    .dist_i   (lane_dist),
    .min_o    (min_dist),
    .have_o   (have_dist)
  );

  logic                mode;
  logic [TARGET_W-1:0] target;

  erm_btn u_btn (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_i      (tick),
    .buttons_i   (buttons),
    .threshold_i (thr_q),
    .mode_o      (mode),
    .target_o    (target)
  );

  // result stage: state registers hold the item until it is captured
  localparam int NEAR_W = DIST_W + 2;

  logic                     pend_q;
  logic                     acc_flag_q;
  logic                     out_valid_q;
  res_t                     res_q;
  res_t                     res_d;
  logic                     cap;
  logic signed [NEAR_W-1:0] d_s;
  logic signed [NEAR_W-1:0] t10_s;
  logic signed [NEAR_W-1:0] lo_s;
  logic [ECHO_W-1:0]        armed_out;

  assign cap           = pend_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !pend_q || cap;

  always_comb begin
    armed_out = '0;
    for (int i = 0; i < NUM_SENSORS && i < ECHO_W; i++) begin
      armed_out[i] = armed_vec[i];
    end
  end

  // no distance yet counts as -1 cm
  assign d_s   = have_dist ? $signed({2'b00, min_dist}) : -NEAR_W'(signed'(10));
  assign t10_s = $signed(NEAR_W'({target, 3'b000}) + NEAR_W'({target, 1'b0}));
  assign lo_s  = t10_s - $signed(NEAR_W'(win_q));

  always_comb begin
    res_d.sensors_armed       = armed_out;
    res_d.start_accepted      = acc_flag_q;
    res_d.near_flag           = (d_s <= t10_s) && (d_s > lo_s);
    res_d.min_distance_tenths = min_dist;
    res_d.distance_valid      = have_dist;
    res_d.target_cm           = target;
    res_d.config_mode         = mode;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      acc_flag_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        pend_q     <= 1'b1;
        acc_flag_q <= start_ok;
      end else if (cap) begin
        pend_q <= 1'b0;
      end
      if (cap) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;

  // checks
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && !cap) |-> !s_axis_tready)
    else $error("item accepted while previous state not captured");

  a_finish_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_vec != '0) |=> ((armed_vec & $past(fin_vec)) == '0))
    else $error("finished lane still armed");

  a_have_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_dist |=> have_dist)
    else $error("distance valid dropped");

  a_start_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_ok |=> ((armed_vec & $past(sel)) == $past(sel)))
    else $error("accepted start did not arm its sensor");

endmodule

@@ rtl/erm_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_lane
// One sensor lane: armed flag, saturating echo-high counter, and the scaled
// distance of the current count.
// ----------------------------------------------------------------------------
module erm_lane
  import erm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lane_ctrl_t         ctrl_i,
  input  logic [SCALE_W-1:0] scale_i,
  output logic               armed_o,
  output logic               finish_o,
  output logic [DIST_W-1:0]  dist_o
);

  logic               armed_q, armed_d;
  logic [PULSE_W-1:0] count_q, count_d;
  logic [PROD_W-1:0]  prod;

  assign finish_o = ctrl_i.tick && armed_q && !ctrl_i.echo && (count_q != '0);

  always_comb begin
    armed_d = armed_q;
    count_d = count_q;
    if (ctrl_i.clear) begin
      count_d = '0;
      if (ctrl_i.arm) begin
        armed_d = 1'b1;
      end
    end else if (ctrl_i.tick && armed_q) begin
      if (ctrl_i.echo) begin
        if (count_q != '1) begin
          count_d = count_q + 1'b1;
        end
      end else if (count_q != '0) begin
        armed_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      count_q <= '0;
    end else begin
      armed_q <= armed_d;
      count_q <= count_d;
    end
  end

  // 16 x 10 product, clipped to the distance width
  assign prod    = PROD_W'(count_q) * PROD_W'(scale_i);
  assign dist_o  = (prod[PROD_W-1:DIST_W] != '0) ? '1 : prod[DIST_W-1:0];
  assign armed_o = armed_q;

endmodule

@@ rtl/erm_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_merge
// Folds the distances of the lanes that finished this item into the running
// minimum.
// ----------------------------------------------------------------------------
module erm_merge
  import erm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [NUM_SENSORS-1:0] finish_i,
  input  logic [DIST_W-1:0]      dist_i [NUM_SENSORS],
  output logic [DIST_W-1:0]      min_o,
  output logic                   have_o
);

  logic [DIST_W-1:0] min_q, min_d;
  logic              have_q, have_d;

  always_comb begin
    // with no distance yet, all ones loses to (or ties with) any candidate
    min_d  = have_q ? min_q : '1;
    have_d = have_q;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      if (finish_i[i]) begin
        have_d = 1'b1;
        if (dist_i[i] < min_d) begin
          min_d = dist_i[i];
        end
      end
    end
    if (!have_d) begin
      min_d = min_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= '0;
      have_q <= 1'b0;
    end else begin
      min_q  <= min_d;
      have_q <= have_d;
    end
  end

  assign min_o  = min_q;
  assign have_o = have_q;

endmodule

@@ rtl/erm_btn.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erm_btn
// Button debounce counters, measure/config mode and target distance.
// ----------------------------------------------------------------------------
module erm_btn
  import erm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tick_i,
  input  logic [BTN_W-1:0]    buttons_i,
  input  logic [DEB_W-1:0]    threshold_i,
  output logic                mode_o,
  output logic [TARGET_W-1:0] target_o
);

  logic [DEB_W-1:0]    deb_q [BTN_W];
  logic [DEB_W-1:0]    deb_d [BTN_W];
  logic [DEB_W-1:0]    deb_step [BTN_W];
  logic [BTN_W-1:0]    qual;
  logic                mode_q, mode_d;
  logic [TARGET_W-1:0] target_q, target_d;
  logic [TARGET_W:0]   raised;

  always_comb begin
    for (int b = 0; b < BTN_W; b++) begin
      if (buttons_i[b]) begin
        deb_step[b] = (deb_q[b] != '1) ? deb_q[b] + 1'b1 : deb_q[b];
      end else begin
        deb_step[b] = (deb_q[b] != '0) ? deb_q[b] - 1'b1 : deb_q[b];
      end
      qual[b] = (deb_step[b] >= threshold_i);
    end
  end

  always_comb begin
    for (int b = 0; b < BTN_W; b++) begin
      deb_d[b] = deb_q[b];
    end
    mode_d   = mode_q;
    target_d = target_q;
    raised   = '0;
    if (tick_i) begin
      deb_d[BTN_MODE] = deb_step[BTN_MODE];
      mode_d          = mode_q ^ qual[BTN_MODE];
      // the other buttons only move while in config mode
      if (mode_d) begin
        deb_d[BTN_UP]   = deb_step[BTN_UP];
        deb_d[BTN_DOWN] = deb_step[BTN_DOWN];
        deb_d[BTN_ZERO] = deb_step[BTN_ZERO];
        if (qual[BTN_UP]) begin
          raised   = {1'b0, target_d} + {1'b0, (target_d >= TARGET_KNEE) ?
                                         TARGET_STEP_SMALL : TARGET_STEP_BIG};
          target_d = raised[TARGET_W] ? '1 : raised[TARGET_W-1:0];
        end
        if (qual[BTN_DOWN] && (target_d >= TARGET_STEP_SMALL)) begin
          target_d = target_d - TARGET_STEP_SMALL;
        end
        if (qual[BTN_ZERO]) begin
          target_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < BTN_W; b++) begin
        deb_q[b] <= '0;
      end
      mode_q   <= 1'b0;
      target_q <= TARGET_RST;
    end else begin
      for (int b = 0; b < BTN_W; b++) begin
        deb_q[b] <= deb_d[b];
      end
      mode_q   <= mode_d;
      target_q <= target_d;
    end
  end

  assign mode_o   = mode_q;
  assign target_o = target_q;

endmodule
